FILE: rtl/core/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// shared constants, types and helpers for the infix expression evaluator
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PtrWidth   = $clog2(StackDepth);
  localparam int unsigned CntWidth   = $clog2(StackDepth + 1);

  typedef logic [ValueWidth-1:0] value_t;
  typedef logic [PtrWidth-1:0]   ptr_t;
  typedef logic [CntWidth-1:0]   cnt_t;

  localparam logic [7:0] ChPow   = 8'h5E;
  localparam logic [7:0] ChMul   = 8'h2A;
  localparam logic [7:0] ChDiv   = 8'h2F;
  localparam logic [7:0] ChAdd   = 8'h2B;
  localparam logic [7:0] ChSub   = 8'h2D;
  localparam logic [7:0] ChOpen  = 8'h28;
  localparam logic [7:0] ChClose = 8'h29;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrUnderflow = 2'd1,
    ErrOverflow  = 2'd2,
    ErrDivZero   = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    AluPow = 2'd0,
    AluMul = 2'd1,
    AluDiv = 2'd2,
    AluAdd = 2'd3
  } alu_op_e;

  // alu request / response between sequencer and arithmetic unit
  typedef struct packed {
    logic    start;
    alu_op_e op;
    logic    sub;
    value_t  a;
    value_t  b;
  } alu_req_t;

  typedef struct packed {
    logic   done;
    logic   div_zero;
    value_t res;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StClassify,
    StReadTop,
    StCheckTop,
    StReadB,
    StReadA,
    StAluGo,
    StAluWait,
    StWriteRes,
    StFinal,
    StEmitRead,
    StEmit
  } state_e;

  // arithmetic unit states
  typedef enum logic [2:0] {AIdle, ADiv, APowMul, APowSq, ADone} alu_st_e;

  // precedence encoded with an offset: -1 -> 0, 1 -> 2, 2 -> 3, 3 -> 4
  function automatic logic [2:0] prec_of(input logic [7:0] c);
    logic [2:0] p;
    p = 3'd0;
    if (c == ChPow) p = 3'd4;
    else if (c == ChMul || c == ChDiv) p = 3'd3;
    else if (c == ChAdd || c == ChSub) p = 3'd2;
    return p;
  endfunction

endpackage

FILE: rtl/core/infix_expression_evaluator_core.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator_core
// two-stack infix evaluator with value and operator stacks held in rams
// ----------------------------------------------------------------------------
// sequencing: a digit or '(' passes StClassify and StFinal before the next
//   character is taken; each reduction runs StReadTop through StWriteRes,
//   waiting in StAluWait for the alu; an underflowing one stops at StReadB
// throughput: one character at a time; the sequencer is busy until done
// the result waits in an output register while no new character is taken
// reset: counts, sticky error and state clear; stack rams are not cleared
module infix_expression_evaluator_core
  import iee_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] result_value, [33:32] error_code
);

  state_e     st_q, st_d;
  cnt_t       vcnt_q, vcnt_d, ocnt_q, ocnt_d;
  logic [1:0] err_q, err_d;
  logic [7:0] ch_q, ch_d;
  logic       last_q, last_d, drain_q, drain_d;
  logic [7:0] op_q, op_d;
  value_t     b_q, b_d, res_q, res_d;
  logic [1:0] oerr_q, oerr_d;
  logic       ovld_q, ovld_d;

  // memory ports
  logic   v_we, o_we;
  ptr_t   v_addr, o_addr;
  value_t v_wdata, v_rdata;
  logic [7:0] o_wdata, o_rdata;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  iee_ram #(.Width(ValueWidth), .Depth(StackDepth)) u_vstack (
    .clk_i, .we_i(v_we), .addr_i(v_addr), .wdata_i(v_wdata), .rdata_o(v_rdata)
  );
  iee_ram #(.Width(8), .Depth(StackDepth)) u_ostack (
    .clk_i, .we_i(o_we), .addr_i(o_addr), .wdata_i(o_wdata), .rdata_o(o_rdata)
  );
  iee_alu u_alu (.clk_i, .rst_ni, .req_i(alu_req), .rsp_o(alu_rsp));

  function automatic logic [1:0] set_err(input logic [1:0] cur, input err_e e);
    return (cur == ErrNone) ? 2'(e) : cur;
  endfunction

  assign s_axis_tready = (st_q == StIdle) && !ovld_q;

  always_comb begin
    st_d = st_q; vcnt_d = vcnt_q; ocnt_d = ocnt_q; err_d = err_q;
    ch_d = ch_q; last_d = last_q; drain_d = drain_q; op_d = op_q; b_d = b_q;
    res_d = res_q; oerr_d = oerr_q; ovld_d = ovld_q;
    v_we = 1'b0; o_we = 1'b0;
    v_addr = '0; o_addr = '0; v_wdata = '0; o_wdata = '0;
    alu_req = '0;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;

    case (st_q)
      StIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          ch_d = s_axis_tdata; last_d = s_axis_tlast; drain_d = 1'b0;
          st_d = StClassify;
        end
      end
      StClassify: begin
        if (ch_q inside {[ChZero:ChNine]}) begin
          if (vcnt_q >= cnt_t'(StackDepth)) err_d = set_err(err_q, ErrOverflow);
          else begin
            v_we = 1'b1; v_addr = ptr_t'(vcnt_q);
            v_wdata = value_t'(ch_q - ChZero);
            vcnt_d = vcnt_q + 1'b1;
          end
          st_d = StFinal;
        end else if (ch_q == ChOpen) begin
          if (ocnt_q >= cnt_t'(StackDepth)) err_d = set_err(err_q, ErrOverflow);
          else begin
            o_we = 1'b1; o_addr = ptr_t'(ocnt_q); o_wdata = ch_q;
            ocnt_d = ocnt_q + 1'b1;
          end
          st_d = StFinal;
        end else begin
          st_d = StReadTop;
        end
      end
      // read top operator to decide reduce / stop
      StReadTop: begin
        if (ocnt_q == '0) begin
          if (!drain_q && ch_q != ChClose) begin
            o_we = 1'b1; o_addr = '0; o_wdata = ch_q;
            ocnt_d = ocnt_q + 1'b1;
          end
          st_d = drain_q ? StEmitRead : StFinal;
        end else begin
          o_addr = ptr_t'(ocnt_q - 1'b1);
          st_d = StCheckTop;
        end
      end
      StCheckTop: begin
        op_d = o_rdata;
        if (drain_q) st_d = StReadB;
        else if (ch_q == ChClose) begin
          if (o_rdata == ChOpen) begin
            ocnt_d = ocnt_q - 1'b1;
            st_d = StFinal;
          end else st_d = StReadB;
        end else if (prec_of(o_rdata) >= prec_of(ch_q)) st_d = StReadB;
        else begin
          if (ocnt_q >= cnt_t'(StackDepth)) err_d = set_err(err_q, ErrOverflow);
          else begin
            o_we = 1'b1; o_addr = ptr_t'(ocnt_q); o_wdata = ch_q;
            ocnt_d = ocnt_q + 1'b1;
          end
          st_d = StFinal;
        end
      end
      StReadB: begin
        ocnt_d = ocnt_q - 1'b1;
        if (vcnt_q < cnt_t'(2)) begin
          err_d = set_err(err_q, ErrUnderflow);
          st_d = StReadTop;
        end else begin
          v_addr = ptr_t'(vcnt_q - 1'b1);
          st_d = StReadA;
        end
      end
      StReadA: begin
        b_d = v_rdata;
        v_addr = ptr_t'(vcnt_q - cnt_t'(2));
        st_d = StAluGo;
      end
      StAluGo: begin
        alu_req.start = 1'b1;
        alu_req.a = v_rdata;
        alu_req.b = b_q;
        alu_req.sub = 1'b1;
        if (op_q == ChPow) alu_req.op = AluPow;
        else if (op_q == ChMul) alu_req.op = AluMul;
        else if (op_q == ChDiv) alu_req.op = AluDiv;
        else begin
          alu_req.op = AluAdd;
          alu_req.sub = (op_q != ChAdd);
        end
        st_d = StAluWait;
      end
      StAluWait: begin
        if (alu_rsp.done) st_d = StWriteRes;
      end
      StWriteRes: begin
        if (alu_rsp.div_zero) err_d = set_err(err_q, ErrDivZero);
        v_we = 1'b1; v_addr = ptr_t'(vcnt_q - cnt_t'(2)); v_wdata = alu_rsp.res;
        vcnt_d = vcnt_q - 1'b1;
        st_d = StReadTop;
      end
      StFinal: begin
        if (last_q) begin
          drain_d = 1'b1;
          st_d = StReadTop;
        end else st_d = StIdle;
      end
      StEmitRead: begin
        v_addr = ptr_t'(vcnt_q - 1'b1);
        st_d = StEmit;
      end
      StEmit: begin
        if (vcnt_q == '0) begin
          res_d = '0;
          oerr_d = set_err(err_q, ErrUnderflow);
        end else begin
          res_d = v_rdata;
          oerr_d = err_q;
        end
        ovld_d = 1'b1;
        vcnt_d = '0; ocnt_d = '0; err_d = ErrNone; drain_d = 1'b0;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; vcnt_q <= '0; ocnt_q <= '0; err_q <= '0;
      ovld_q <= 1'b0; drain_q <= 1'b0;
    end else begin
      st_q <= st_d; vcnt_q <= vcnt_d; ocnt_q <= ocnt_d; err_q <= err_d;
      ovld_q <= ovld_d; drain_q <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d; last_q <= last_d; op_q <= op_d; b_q <= b_d;
    res_q <= res_d; oerr_q <= oerr_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {6'd0, oerr_q, res_q};

  // counts never exceed the stack depth
  a_vcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= cnt_t'(StackDepth)) else $error("value count out of range");
  a_ocnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= cnt_t'(StackDepth)) else $error("operator count out of range");
  // a result is emitted with stacks cleared
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StEmit |=> vcnt_q == '0 && ocnt_q == '0 && err_q == '0)
    else $error("stacks not cleared after result");
  // no new character taken while a result waits
  a_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");

endmodule

FILE: rtl/core/iee_ram.sv
// ----------------------------------------------------------------------------
// iee_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: rtl/core/iee_alu.sv
// ----------------------------------------------------------------------------
// iee_alu
// multi-cycle arithmetic: add/sub, multiply, restoring divide, power
// ----------------------------------------------------------------------------
module iee_alu
  import iee_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  localparam int unsigned BitCntW = $clog2(ValueWidth + 1);

  alu_st_e            st_q, st_d;
  value_t             a_q, a_d, b_q, b_d, acc_q, acc_d, rem_q, rem_d;
  logic               neg_q, neg_d, dz_q, dz_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;
  value_t             mag_a, mag_b, rem_sh;
  logic [ValueWidth:0] trial;

  assign mag_a = req_i.a[ValueWidth-1] ? (~req_i.a + 1'b1) : req_i.a;
  assign mag_b = req_i.b[ValueWidth-1] ? (~req_i.b + 1'b1) : req_i.b;
  assign rem_sh = {rem_q[ValueWidth-2:0], a_q[ValueWidth-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, b_q};

  always_comb begin
    st_d = st_q; a_d = a_q; b_d = b_q; acc_d = acc_q; rem_d = rem_q;
    neg_d = neg_q; dz_d = dz_q; cnt_d = cnt_q;
    case (st_q)
      AIdle: begin
        if (req_i.start) begin
          dz_d = 1'b0;
          st_d = ADone;
          case (req_i.op)
            AluAdd: acc_d = req_i.sub ? req_i.a - req_i.b : req_i.a + req_i.b;
            AluMul: acc_d = value_t'(req_i.a * req_i.b);
            AluDiv: begin
              if (req_i.b == '0) begin
                dz_d = 1'b1;
                acc_d = '0;
              end else begin
                a_d = mag_a; b_d = mag_b; rem_d = '0; acc_d = '0;
                neg_d = req_i.a[ValueWidth-1] ^ req_i.b[ValueWidth-1];
                cnt_d = BitCntW'(ValueWidth);
                st_d = ADiv;
              end
            end
            AluPow: begin
              if (req_i.b[ValueWidth-1]) begin
                if (req_i.a == value_t'(1)) acc_d = value_t'(1);
                else if (req_i.a == '1) acc_d = req_i.b[0] ? '1 : value_t'(1);
                else acc_d = '0;
              end else begin
                a_d = req_i.a; b_d = req_i.b; acc_d = value_t'(1);
                st_d = APowMul;
              end
            end
            default: acc_d = '0;
          endcase
        end
      end
      ADiv: begin
        if (!trial[ValueWidth]) begin
          rem_d = trial[ValueWidth-1:0];
          acc_d = {acc_q[ValueWidth-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          acc_d = {acc_q[ValueWidth-2:0], 1'b0};
        end
        a_d = {a_q[ValueWidth-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == BitCntW'(1)) begin
          if (neg_q) acc_d = ~acc_d + 1'b1;
          st_d = ADone;
        end
      end
      // one multiply per cycle, registered between steps
      APowMul: begin
        if (b_q == '0) st_d = ADone;
        else begin
          if (b_q[0]) acc_d = value_t'(acc_q * a_q);
          st_d = APowSq;
        end
      end
      APowSq: begin
        a_d = value_t'(a_q * a_q);
        b_d = b_q >> 1;
        st_d = APowMul;
      end
      ADone: st_d = AIdle;
      default: st_d = AIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= AIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; acc_q <= acc_d; rem_q <= rem_d;
    neg_q <= neg_d; dz_q <= dz_d; cnt_q <= cnt_d;
  end

  assign rsp_o.done     = (st_q == ADone);
  assign rsp_o.div_zero = dz_q;
  assign rsp_o.res      = acc_q;

endmodule
